// File: sv/dsl_pkg.sv
package dsl_pkg;

    localparam int FREQ_WORD_BITS = 32;
    localparam int PHASE_BITS     = 5;
    localparam int CTRL_BITS      = 3;
    localparam int FREQ_BITS      = 26;
    localparam int PHASE_IN_BITS  = 10;
    localparam int SWEEP_BITS     = 28;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int PULSE_CNT_BITS = 6;

    localparam logic [2:0] MODE_LOAD    = 3'd0;
    localparam logic [2:0] MODE_PWDN    = 3'd1;
    localparam logic [2:0] MODE_RESET   = 3'd2;
    localparam logic [2:0] MODE_RESTART = 3'd3;
    localparam logic [2:0] MODE_STEP    = 3'd4;

    localparam logic [1:0] KIND_CLK = 2'd0;
    localparam logic [1:0] KIND_UPD = 2'd1;
    localparam logic [1:0] KIND_RST = 2'd2;

    localparam logic [1:0] SWEEP_UP     = 2'd0;
    localparam logic [1:0] SWEEP_DOWN   = 2'd1;
    localparam logic [1:0] SWEEP_BOUNCE = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_TUNING    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SWEEP_MIN = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SWEEP_MAX = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SWEEP_INC = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SWEEP_KND = 3'd4;

    localparam logic [31:0] TUNING_RESET = 32'd576460752;
    localparam logic [FREQ_BITS-1:0] SWEEP_MIN_RESET = 26'd0;
    localparam logic [FREQ_BITS-1:0] SWEEP_MAX_RESET = 26'd1000000;
    localparam logic [FREQ_BITS-1:0] SWEEP_INC_RESET = 26'd1000;

    localparam logic [PHASE_IN_BITS-1:0] DEG_360 = 10'd360;
    localparam logic [PHASE_IN_BITS-1:0] DEG_720 = 10'd720;
    // floor(x / 23) for x up to 720: x * ceil(2^16 / 23) >> 16
    localparam logic [11:0] RECIP_23   = 12'd2850;
    localparam int          RECIP_SHFT = 16;

    localparam logic [7:0] PD_WORD = 8'h04;

    localparam logic [PULSE_CNT_BITS-1:0] LOAD_LAST  = 6'd40;
    localparam logic [PULSE_CNT_BITS-1:0] PWDN_LAST  = 6'd9;
    localparam logic [PULSE_CNT_BITS-1:0] RESET_PRE  = 6'd3;
    localparam logic [PULSE_CNT_BITS-1:0] POS_CTRL   = 6'd32;
    localparam logic [PULSE_CNT_BITS-1:0] POS_PHASE  = 6'd35;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_PWDN,
        CMD_RESET
    } t_cmd;

    typedef struct packed {
        t_cmd                      cmd;
        logic [FREQ_WORD_BITS-1:0] word;
        logic [PHASE_BITS-1:0]     idx;
    } t_entry;

    typedef struct packed {
        logic [31:0]          tuning_per_hz;
        logic [FREQ_BITS-1:0] sweep_min;
        logic [FREQ_BITS-1:0] sweep_max;
        logic [FREQ_BITS-1:0] sweep_increment;
        logic [1:0]           sweep_kind;
    } t_cfg;

endpackage

// File: sv/dsl_cmd_if.sv
interface dsl_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [25:0] frequency_hz;
    logic [9:0]  phase_degrees;

    modport source (output valid, output mode, output frequency_hz, output phase_degrees,
                    input ready);
    modport sink (input valid, input mode, input frequency_hz, input phase_degrees,
                  output ready);
endinterface

// File: sv/dsl_pulse_if.sv
interface dsl_pulse_if;
    logic       valid;
    logic       ready;
    logic       serial_data;
    logic [1:0] pulse_kind;
    logic       last_of_run;

    modport source (output valid, output serial_data, output pulse_kind, output last_of_run,
                    input ready);
    modport sink (input valid, input serial_data, input pulse_kind, input last_of_run,
                  output ready);
endinterface

// File: sv/dds_serial_loader_with_sweep.sv
// Channel   Dir  Fields                                  Transfer
// i_cmd     in   mode, frequency_hz, phase_degrees       valid & ready
// o_pulse   out  serial_data, pulse_kind, last_of_run    valid & ready
// i_cfg_*   in   register index, data                    i_cfg_we
//
// One pulse per cycle while o_pulse is ready: load and sweep commands send 41 pulses,
// power down 10, reset sequence 44; the pulse sequencer sets the rate.
// A command is accepted while the command queue (QUEUE_DEPTH entries) has room.
// Reset is synchronous, active low; it empties the queue and clears the sweep state.
// A stall on o_pulse holds the pulse register and the sequencer.
module dds_serial_loader_with_sweep
    import dsl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    dsl_cmd_if.sink                  i_cmd,
    dsl_pulse_if.source              o_pulse
);

    t_cfg   r_cfg;
    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    t_entry q_entry;
    t_entry q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tuning_per_hz   <= TUNING_RESET;
            r_cfg.sweep_min       <= SWEEP_MIN_RESET;
            r_cfg.sweep_max       <= SWEEP_MAX_RESET;
            r_cfg.sweep_increment <= SWEEP_INC_RESET;
            r_cfg.sweep_kind      <= SWEEP_UP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TUNING:    r_cfg.tuning_per_hz   <= i_cfg_data;
                REG_SWEEP_MIN: r_cfg.sweep_min       <= i_cfg_data[FREQ_BITS-1:0];
                REG_SWEEP_MAX: r_cfg.sweep_max       <= i_cfg_data[FREQ_BITS-1:0];
                REG_SWEEP_INC: r_cfg.sweep_increment <= i_cfg_data[FREQ_BITS-1:0];
                REG_SWEEP_KND: r_cfg.sweep_kind      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    dsl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (i_cmd),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_entry (q_entry)
    );

    dsl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    dsl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_pulse   (o_pulse)
    );

endmodule

// File: sv/dsl_front.sv
module dsl_front
    import dsl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    dsl_cmd_if.sink   i_cmd,
    input  logic      i_q_full,
    output logic      o_q_push,
    output t_entry    o_q_entry
);

    logic [SWEEP_BITS-1:0]     r_sweep_freq, n_sweep_freq;
    logic                      r_sweep_desc, n_sweep_desc;
    logic [SWEEP_BITS-1:0]     base;
    logic                      desc;
    logic [SWEEP_BITS-1:0]     sum_up, sum_dn;
    logic signed [SWEEP_BITS-1:0] lo, hi;
    logic                      accept;
    logic                      is_sweep;
    t_cmd                      entry_cmd;
    logic [FREQ_BITS:0]        f_op;
    logic [FREQ_BITS+32:0]     f_prod;
    logic [PHASE_IN_BITS-1:0]  phase_sel;
    logic [PHASE_IN_BITS-1:0]  phase_wrap;
    logic [PHASE_IN_BITS-1:0]  phase_x2;
    logic [21:0]               idx_prod;

    assign i_cmd.ready = !i_q_full;
    assign accept      = i_cmd.valid && !i_q_full;
    assign is_sweep    = (i_cmd.mode == MODE_RESTART) || (i_cmd.mode == MODE_STEP);
    assign lo          = $signed({2'b00, i_cfg.sweep_min});
    assign hi          = $signed({2'b00, i_cfg.sweep_max});

    always_comb begin
        base = r_sweep_freq;
        desc = r_sweep_desc;
        if (i_cmd.mode == MODE_RESTART) begin
            if (i_cfg.sweep_kind == SWEEP_DOWN) begin
                base = {2'b00, i_cfg.sweep_max};
                desc = 1'b1;
            end else begin
                base = {2'b00, i_cfg.sweep_min};
                desc = 1'b0;
            end
        end
    end

    assign sum_up = base + {2'b00, i_cfg.sweep_increment};
    assign sum_dn = base - {2'b00, i_cfg.sweep_increment};

    always_comb begin
        n_sweep_desc = desc;
        unique case (i_cfg.sweep_kind)
            SWEEP_DOWN: begin
                n_sweep_freq = sum_dn;
                if ($signed(sum_dn) < lo) begin
                    n_sweep_freq = {2'b00, i_cfg.sweep_max};
                end
            end
            SWEEP_BOUNCE: begin
                n_sweep_freq = desc ? sum_dn : sum_up;
                if (($signed(n_sweep_freq) > hi) || ($signed(n_sweep_freq) < lo)) begin
                    n_sweep_desc = !desc;
                end
            end
            default: begin
                n_sweep_freq = sum_up;
                if ($signed(sum_up) > hi) begin
                    n_sweep_freq = {2'b00, i_cfg.sweep_min};
                end
            end
        endcase
    end

    always_comb begin
        f_op      = '0;
        phase_sel = '0;
        entry_cmd = CMD_LOAD;
        unique case (i_cmd.mode)
            MODE_LOAD: begin
                f_op      = {1'b0, i_cmd.frequency_hz};
                phase_sel = i_cmd.phase_degrees;
            end
            MODE_PWDN:  entry_cmd = CMD_PWDN;
            MODE_RESET: entry_cmd = CMD_RESET;
            MODE_RESTART, MODE_STEP: begin
                f_op = base[SWEEP_BITS-1] ? '0 : base[FREQ_BITS:0];
            end
            default: f_op = '0;
        endcase
    end

    assign o_q_entry.cmd  = entry_cmd;
    assign f_prod         = f_op * i_cfg.tuning_per_hz;
    assign o_q_entry.word = f_prod[24 +: FREQ_WORD_BITS];

    always_comb begin
        if (phase_sel > DEG_720) begin
            phase_wrap = phase_sel - DEG_720;
        end else if (phase_sel > DEG_360) begin
            phase_wrap = phase_sel - DEG_360;
        end else begin
            phase_wrap = phase_sel;
        end
    end

    assign phase_x2      = {phase_wrap[PHASE_IN_BITS-2:0], 1'b0};
    assign idx_prod      = phase_x2 * RECIP_23;
    assign o_q_entry.idx = idx_prod[RECIP_SHFT +: PHASE_BITS];

    assign o_q_push = accept && (i_cmd.mode <= MODE_STEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_freq <= '0;
            r_sweep_desc <= 1'b0;
        end else if (accept && is_sweep) begin
            r_sweep_freq <= n_sweep_freq;
            r_sweep_desc <= n_sweep_desc;
        end
    end

endmodule

// File: sv/dsl_queue.sv
module dsl_queue
    import dsl_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_head
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    t_entry              r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: sv/dsl_back.sv
module dsl_back
    import dsl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_entry      i_q_head,
    output logic        o_q_pop,
    dsl_pulse_if.source o_pulse
);

    logic [PULSE_CNT_BITS-1:0] r_cnt;
    logic                      r_valid;
    logic                      r_data;
    logic [1:0]                r_kind;
    logic                      r_last;
    logic                      step;
    logic [PULSE_CNT_BITS-1:0] lpos;
    logic [PULSE_CNT_BITS-1:0] psub;
    logic [PULSE_CNT_BITS-1:0] pdsub;
    logic                      l_data, n_data;
    logic [1:0]                l_kind, n_kind;
    logic                      n_last;

    assign step = i_q_valid && (!r_valid || o_pulse.ready);

    assign lpos  = (i_q_head.cmd == CMD_RESET) ? r_cnt - RESET_PRE : r_cnt;
    assign psub  = lpos - POS_PHASE;
    assign pdsub = r_cnt - 6'd1;

    always_comb begin
        l_data = 1'b0;
        l_kind = KIND_CLK;
        if (lpos < POS_CTRL) begin
            l_data = i_q_head.word[lpos[4:0]];
        end else if (lpos < POS_PHASE) begin
            l_data = 1'b0;
        end else if (lpos < LOAD_LAST) begin
            l_data = i_q_head.idx[psub[2:0]];
        end else begin
            l_kind = KIND_UPD;
        end
    end

    always_comb begin
        n_data = 1'b0;
        n_kind = KIND_CLK;
        n_last = 1'b0;
        unique case (i_q_head.cmd)
            CMD_PWDN: begin
                n_last = (r_cnt == PWDN_LAST);
                if ((r_cnt == '0) || n_last) begin
                    n_kind = KIND_UPD;
                end else begin
                    n_data = PD_WORD[pdsub[2:0]];
                end
            end
            CMD_RESET: begin
                if (r_cnt == 6'd0) begin
                    n_kind = KIND_CLK;
                end else if (r_cnt == 6'd1) begin
                    n_kind = KIND_RST;
                end else if (r_cnt == 6'd2) begin
                    n_kind = KIND_UPD;
                end else begin
                    n_data = l_data;
                    n_kind = l_kind;
                    n_last = (lpos == LOAD_LAST);
                end
            end
            default: begin
                n_data = l_data;
                n_kind = l_kind;
                n_last = (lpos == LOAD_LAST);
            end
        endcase
    end

    assign o_q_pop = step && n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (step) begin
                r_valid <= 1'b1;
                r_cnt   <= n_last ? '0 : r_cnt + 1'b1;
            end else if (o_pulse.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_data <= n_data;
            r_kind <= n_kind;
            r_last <= n_last;
        end
    end

    assign o_pulse.valid       = r_valid;
    assign o_pulse.serial_data = r_data;
    assign o_pulse.pulse_kind  = r_kind;
    assign o_pulse.last_of_run = r_last;

endmodule

// File: tb/tb_dds_serial_loader_with_sweep.sv
`timescale 1ns / 100ps

module tb_dds_serial_loader_with_sweep;
    import dsl_pkg::*;

    localparam logic [2:0] MODE_SPARE_LO = MODE_STEP + 3'd1;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam logic [1:0] SWEEP_SPARE = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = REG_SWEEP_KND + 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

    localparam int FREQ_TOP = 62500000;
    localparam int FULL_TURN = 360;
    localparam int DEG_STEP_X2 = 23;

    localparam int NPHASES = 9;
    localparam int PHASE_ITEMS = 50;
    localparam int HOLD_PHASE = 5;
    localparam int PAUSE_PHASE = 6;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 150;
    localparam int STUCK_LIMIT = 4000;
    localparam int RESET_CYCLES = 12;
    localparam int NDIRECTED = 21;

    typedef struct packed {
        logic       data;
        logic [1:0] kind;
        logic       last;
    } t_pulse;

    typedef struct packed {
        logic [2:0]                mode;
        logic [FREQ_BITS-1:0]      freq;
        logic [PHASE_IN_BITS-1:0]  phase;
        logic                      fixed_exp;
        logic [FREQ_WORD_BITS-1:0] word;
        logic [PHASE_BITS-1:0]     idx;
    } t_stim;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    dsl_cmd_if   cmd_ch();
    dsl_pulse_if pulse_ch();

    dds_serial_loader_with_sweep dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_ch),
        .o_pulse    (pulse_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [31:0]           cfg_tuning = TUNING_RESET;
    logic [FREQ_BITS-1:0]  cfg_min    = SWEEP_MIN_RESET;
    logic [FREQ_BITS-1:0]  cfg_max    = SWEEP_MAX_RESET;
    logic [FREQ_BITS-1:0]  cfg_inc    = SWEEP_INC_RESET;
    logic [1:0]            cfg_kind   = SWEEP_UP;
    logic [SWEEP_BITS-1:0] sw_freq    = '0;
    logic                  sw_down    = 1'b0;

    t_pulse pulse_q[$];
    int     mismatches = 0;
    int     stuck_cycles = 0;
    bit     idle_on = 1'b1;
    bit     hold_req = 1'b0;

    t_stim directed_tbl [0:NDIRECTED-1] = '{
        '{MODE_RESET,   26'd0,        10'd0,    1'b0, 32'd0,          5'd0},
        '{MODE_LOAD,    26'd0,        10'd0,    1'b1, 32'd0,          5'd0},
        '{MODE_LOAD,    26'd0,        10'd360,  1'b1, 32'd0,          5'd31},
        '{MODE_LOAD,    26'd0,        10'd361,  1'b1, 32'd0,          5'd0},
        '{MODE_LOAD,    26'd0,        10'd1023, 1'b1, 32'd0,          5'd26},
        '{MODE_LOAD,    26'd1,        10'd0,    1'b1, 32'd34,         5'd0},
        '{MODE_LOAD,    26'd62500000, 10'd23,   1'b1, 32'd2147483646, 5'd2},
        '{MODE_LOAD,    26'h3FFFFFF,  10'd720,  1'b0, 32'd0,          5'd0},
        '{MODE_LOAD,    26'h2AAAAAA,  10'h2AA,  1'b0, 32'd0,          5'd0},
        '{MODE_LOAD,    26'h1555555,  10'h155,  1'b0, 32'd0,          5'd0},
        '{MODE_LOAD,    26'd33554432, 10'd721,  1'b0, 32'd0,          5'd0},
        '{MODE_PWDN,    26'd0,        10'd0,    1'b0, 32'd0,          5'd0},
        '{MODE_RESTART, 26'd0,        10'd0,    1'b0, 32'd0,          5'd0},
        '{MODE_STEP,    26'd0,        10'd0,    1'b0, 32'd0,          5'd0},
        '{MODE_STEP,    26'd0,        10'd0,    1'b0, 32'd0,          5'd0},
        '{MODE_SPARE_LO, 26'd12,      10'd3,    1'b0, 32'd0,          5'd0},
        '{MODE_SPARE_LO + 3'd1, 26'd0, 10'd0,   1'b0, 32'd0,          5'd0},
        '{MODE_SPARE_HI, 26'h3FFFFFF, 10'h3FF,  1'b0, 32'd0,          5'd0},
        '{MODE_STEP,    26'd0,        10'd0,    1'b0, 32'd0,          5'd0},
        '{MODE_PWDN,    26'd5,        10'd9,    1'b0, 32'd0,          5'd0},
        '{MODE_LOAD,    26'd12345,    10'd359,  1'b0, 32'd0,          5'd0}
    };

    function automatic void push_pulse(logic d, logic [1:0] k);
        pulse_q.push_back('{data: d, kind: k, last: 1'b0});
    endfunction

    function automatic void close_run(int n0);
        if (pulse_q.size() > n0)
            pulse_q[pulse_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void load_pulses(logic [31:0] word, logic [4:0] idx);
        int b;
        for (b = 0; b < FREQ_WORD_BITS; b++)
            push_pulse(word[b], KIND_CLK);
        for (b = 0; b < CTRL_BITS; b++)
            push_pulse(1'b0, KIND_CLK);
        for (b = 0; b < PHASE_BITS; b++)
            push_pulse(idx[b], KIND_CLK);
        push_pulse(1'b0, KIND_UPD);
    endfunction

    function automatic logic [31:0] tuning_word(logic [63:0] hz);
        logic [63:0] prod;
        prod = hz * {32'd0, cfg_tuning};
        return prod[55:24];
    endfunction

    function automatic logic [4:0] phase_index(logic [9:0] deg);
        int p;
        p = deg;
        while (p > FULL_TURN)
            p -= FULL_TURN;
        return 5'((p * 2) / DEG_STEP_X2);
    endfunction

    function automatic longint sweep_signed(logic [SWEEP_BITS-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic void sweep_load_and_advance();
        longint                cur;
        logic [SWEEP_BITS-1:0] nxt;
        cur = sweep_signed(sw_freq);
        load_pulses(tuning_word(cur < 0 ? 64'd0 : 64'(cur)), 5'd0);
        case (cfg_kind)
            SWEEP_DOWN: begin
                nxt = sw_freq - 28'(cfg_inc);
                if (sweep_signed(nxt) < longint'(cfg_min))
                    nxt = 28'(cfg_max);
            end
            SWEEP_BOUNCE: begin
                nxt = sw_down ? sw_freq - 28'(cfg_inc) : sw_freq + 28'(cfg_inc);
                if (sweep_signed(nxt) > longint'(cfg_max) ||
                    sweep_signed(nxt) < longint'(cfg_min))
                    sw_down = !sw_down;
            end
            default: begin
                nxt = sw_freq + 28'(cfg_inc);
                if (sweep_signed(nxt) > longint'(cfg_max))
                    nxt = 28'(cfg_min);
            end
        endcase
        sw_freq = nxt;
    endfunction

    function automatic void predict_cmd(logic [2:0] mode, logic [25:0] hz, logic [9:0] deg);
        int n0;
        int b;
        n0 = pulse_q.size();
        case (mode)
            MODE_LOAD:
                load_pulses(tuning_word(64'(hz)), phase_index(deg));
            MODE_PWDN: begin
                push_pulse(1'b0, KIND_UPD);
                for (b = 0; b < 8; b++)
                    push_pulse(PD_WORD[b], KIND_CLK);
                push_pulse(1'b0, KIND_UPD);
            end
            MODE_RESET: begin
                push_pulse(1'b0, KIND_CLK);
                push_pulse(1'b0, KIND_RST);
                push_pulse(1'b0, KIND_UPD);
                load_pulses(tuning_word(64'd0), 5'd0);
            end
            MODE_RESTART: begin
                sw_down = (cfg_kind == SWEEP_DOWN);
                sw_freq = sw_down ? 28'(cfg_max) : 28'(cfg_min);
                sweep_load_and_advance();
            end
            MODE_STEP:
                sweep_load_and_advance();
            default: ;
        endcase
        close_run(n0);
    endfunction

    function automatic void report_pulse(string what, t_pulse e, t_pulse g);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected data=%0b kind=%0d last=%0b, got data=%0b kind=%0d last=%0b",
                     what, e.data, e.kind, e.last, g.data, g.kind, g.last);
    endfunction

    function automatic t_stim random_item();
        t_stim s;
        int    r;
        s = '0;
        r = $urandom_range(0, 99);
        s.phase = 10'($urandom_range(0, 1023));
        s.freq = ($urandom_range(0, 7) == 0) ? 26'($urandom) : 26'($urandom_range(0, FREQ_TOP));
        if (r < 45)
            s.mode = MODE_LOAD;
        else if (r < 80)
            s.mode = MODE_STEP;
        else if (r < 87)
            s.mode = MODE_RESTART;
        else if (r < 93)
            s.mode = MODE_PWDN;
        else if (r < 98)
            s.mode = MODE_RESET;
        else
            s.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        return s;
    endfunction

    task automatic send_cmd(input t_stim s);
        int n0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.mode          <= s.mode;
        cmd_ch.frequency_hz  <= s.freq;
        cmd_ch.phase_degrees <= s.phase;
        @(posedge i_clk);
        while (!cmd_ch.ready)
            @(posedge i_clk);
        if (s.fixed_exp) begin
            n0 = pulse_q.size();
            load_pulses(s.word, s.idx);
            close_run(n0);
        end else begin
            predict_cmd(s.mode, s.freq, s.phase);
        end
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        case (idx)
            REG_TUNING:    cfg_tuning = d;
            REG_SWEEP_MIN: cfg_min = d[FREQ_BITS-1:0];
            REG_SWEEP_MAX: cfg_max = d[FREQ_BITS-1:0];
            REG_SWEEP_INC: cfg_inc = d[FREQ_BITS-1:0];
            REG_SWEEP_KND: cfg_kind = d[1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic configure(input int ph);
        logic [31:0]          tun;
        logic [FREQ_BITS-1:0] lo;
        logic [FREQ_BITS-1:0] hi;
        logic [FREQ_BITS-1:0] inc;
        logic [1:0]           kind;
        cmd_ch.valid <= 1'b0;
        wait (pulse_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        case (ph)
            0: begin
                tun = 32'hFFFF_FFFF; lo = '0; hi = 26'(FREQ_TOP); inc = 26'(FREQ_TOP);
                kind = SWEEP_BOUNCE;
            end
            1: begin
                tun = '0; lo = '0; hi = '0; inc = '0; kind = SWEEP_SPARE;
            end
            2: begin
                tun = 32'h0100_0000; lo = 26'd1000; hi = 26'd5000; inc = 26'd700;
                kind = SWEEP_DOWN;
            end
            3: begin
                tun = $urandom; lo = 26'(FREQ_TOP); hi = '0;
                inc = 26'($urandom_range(1, FREQ_TOP)); kind = SWEEP_UP;
            end
            default: begin
                tun = $urandom;
                hi = 26'($urandom_range(0, FREQ_TOP));
                lo = 26'($urandom_range(0, hi));
                if ($urandom_range(0, 3) == 0)
                    inc = 26'($urandom_range(0, FREQ_TOP));
                else
                    inc = 26'($urandom_range(0, (hi - lo) / 6 + 1));
                kind = 2'($urandom_range(0, 3));
            end
        endcase
        write_reg(REG_TUNING, tun);
        write_reg(REG_SWEEP_MIN, 32'(lo));
        write_reg(REG_SWEEP_MAX, 32'(hi));
        write_reg(REG_SWEEP_INC, 32'(inc));
        write_reg(REG_SWEEP_KND, 32'(kind));
        write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        pulse_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pulse_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
                pulse_ch.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                pulse_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
            end else begin
                pulse_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_pulses
        t_pulse got;
        t_pulse want;
        if (i_rst_n && pulse_ch.valid && pulse_ch.ready) begin
            got = '{data: pulse_ch.serial_data, kind: pulse_ch.pulse_kind,
                    last: pulse_ch.last_of_run};
            if (pulse_q.size() == 0) begin
                report_pulse("pulse with no command pending", '0, got);
            end else begin
                want = pulse_q.pop_front();
                if (got.data !== want.data || got.kind !== want.kind || got.last !== want.last)
                    report_pulse("pulse mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (pulse_ch.valid && pulse_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("tb_dds_serial_loader_with_sweep NOT OK");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        t_stim s;
        int    ph;
        int    sent;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.mode          = MODE_LOAD;
        cmd_ch.frequency_hz  = '0;
        cmd_ch.phase_degrees = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NDIRECTED; i++)
            send_cmd(directed_tbl[i]);

        for (ph = 0; ph < NPHASES; ph++) begin
            configure(ph);
            idle_on = (ph != NPHASES - 1) && (ph % 3 != 2);
            s = '0;
            s.mode = MODE_RESTART;
            send_cmd(s);
            sent = 1;
            while (sent < PHASE_ITEMS) begin
                if (ph == HOLD_PHASE && sent == 10)
                    hold_req = 1'b1;
                if (ph == PAUSE_PHASE && sent == 25) begin
                    cmd_ch.valid <= 1'b0;
                    wait (pulse_q.size() == 0);
                    @(negedge i_clk);
                end
                s = random_item();
                send_cmd(s);
                if (s.mode <= MODE_STEP)
                    sent++;
            end
        end

        cmd_ch.valid <= 1'b0;
        wait (pulse_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pulse_q.size() == 0)
            $display("tb_dds_serial_loader_with_sweep OK");
        else
            $display("tb_dds_serial_loader_with_sweep NOT OK");
        $finish;
    end

endmodule

// File: files.f
sv/dsl_pkg.sv
sv/dsl_cmd_if.sv
sv/dsl_pulse_if.sv
sv/dsl_front.sv
sv/dsl_queue.sv
sv/dsl_back.sv
sv/dds_serial_loader_with_sweep.sv
tb/tb_dds_serial_loader_with_sweep.sv
